>>> src/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared codes, widths and command/status types of the video register port.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int OP_W   = 2;
  localparam int SEL_W  = 4;
  localparam int DATA_W = 16;
  localparam int BYTE_W = 8;
  localparam int VADDR_W = 16;
  localparam int CADDR_W = 8;
  localparam int BRIGHT_W = 3;
  localparam int STEP_SEL_W = 2;
  localparam int PAL_W = 15;

  localparam int VRAM_BYTES_DEF    = 65536;
  localparam int CGRAM_ENTRIES_DEF = 256;

  // bus operations
  localparam logic [OP_W-1:0] OP_READ8   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ16  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE8  = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE16 = 2'd3;

  // decoded register selects
  localparam logic [SEL_W-1:0] SEL_INIDISP  = 4'd0;
  localparam logic [SEL_W-1:0] SEL_NMITIMEN = 4'd1;
  localparam logic [SEL_W-1:0] SEL_VMAIN    = 4'd2;
  localparam logic [SEL_W-1:0] SEL_VMADDL   = 4'd3;
  localparam logic [SEL_W-1:0] SEL_VMADDH   = 4'd4;
  localparam logic [SEL_W-1:0] SEL_VMDATAL  = 4'd5;
  localparam logic [SEL_W-1:0] SEL_VMDATAH  = 4'd6;
  localparam logic [SEL_W-1:0] SEL_CGADD    = 4'd7;
  localparam logic [SEL_W-1:0] SEL_CGDATA   = 4'd8;
  localparam logic [SEL_W-1:0] SEL_VTIMEL   = 4'd9;
  localparam logic [SEL_W-1:0] SEL_VTIMEH   = 4'd10;
  localparam logic [SEL_W-1:0] SEL_OAMADDL  = 4'd11;
  localparam logic [SEL_W-1:0] SEL_OTHER    = 4'd12;
  localparam logic [SEL_W-1:0] SEL_RDNMI    = 4'd13;
  localparam logic [SEL_W-1:0] SEL_UNMAPPED = 4'd14;

  // VMAIN increment step codes
  localparam logic [STEP_SEL_W-1:0] STEP_SEL_1  = 2'd0;
  localparam logic [STEP_SEL_W-1:0] STEP_SEL_32 = 2'd1;
  localparam logic [VADDR_W-1:0] STEP_1   = 16'd1;
  localparam logic [VADDR_W-1:0] STEP_32  = 16'd32;
  localparam logic [VADDR_W-1:0] STEP_128 = 16'd128;

  typedef struct packed {
    logic step_first;   // item accepted: apply first (or only) byte, capture flags
    logic step_second;  // apply high byte of a split 16-bit write
  } ctl_cmd_t;

  typedef struct packed {
    logic need_second;  // item at the input is a split 16-bit write
  } dp_stat_t;

endpackage

>>> src/video_register_port_vram_cgram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_register_port_vram_cgram_unit
// Bus-side register port of the video unit: display control, VRAM address
// and data writes, CGRAM address and palette word assembly.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+---------------------------------
// in_     | in        | in_valid/in_stall  | operation, register_select, data
// out_    | out       | out_valid/out_stall| read_data, access_error, status
//
// - One item at a time: after the accept cycle the result is shown the next
//   cycle, or after a high-byte step for a 16-bit write to VMADDL or VMDATAL,
//   which the sequencer splits into a low-byte and a high-byte step.
// - The result holds while out_stall is high; in_stall stays high until
//   the result is taken.
// - rst_n is synchronous; the sequencer and the programmable registers reset
//   to zero. VRAM and CGRAM contents are not cleared (write-only here).
// - VRAM byte writes land after the vw_ and vw2_ pipeline registers, through a
//   reciprocal-multiply address fold; results never wait on them.
//
module video_register_port_vram_cgram_unit #(
  parameter int VRAM_BYTES    = vrp_pkg::VRAM_BYTES_DEF,
  parameter int CGRAM_ENTRIES = vrp_pkg::CGRAM_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [vrp_pkg::OP_W-1:0]       in_operation,
  input  logic [vrp_pkg::SEL_W-1:0]      in_register_select,
  input  logic [vrp_pkg::DATA_W-1:0]     in_write_data,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vrp_pkg::DATA_W-1:0]     out_read_data,
  output logic                           out_access_error,
  output logic                           out_forced_blank,
  output logic [vrp_pkg::BRIGHT_W-1:0]   out_brightness,
  output logic                           out_nmi_enable,
  output logic [vrp_pkg::VADDR_W-1:0]    out_vram_word_address,
  output logic [vrp_pkg::CADDR_W-1:0]    out_cgram_address,
  output logic                           out_cgram_low_pending
);

  vrp_pkg::ctl_cmd_t cmd;
  vrp_pkg::dp_stat_t stat;

  // sequencer
  vrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // registers and memory write paths
  vrp_dp #(
    .VRAM_BYTES    (VRAM_BYTES),
    .CGRAM_ENTRIES (CGRAM_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_register_select (in_register_select),
    .in_write_data      (in_write_data),
    .access_error       (out_access_error),
    .forced_blank       (out_forced_blank),
    .brightness         (out_brightness),
    .nmi_enable         (out_nmi_enable),
    .vram_word_address  (out_vram_word_address),
    .cgram_address      (out_cgram_address),
    .cgram_low_pending  (out_cgram_low_pending)
  );

  // reads are not backed by any storage here
  assign out_read_data = '0;

  // an accepted item blocks the input until its result is taken
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accept");

  // the high-byte step only directly follows an accept
  a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_second |-> $past(cmd.step_first))
    else $error("high-byte step without preceding accept");

  // reads change nothing and never flag an error
  a_read_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_operation == vrp_pkg::OP_READ8 || in_operation == vrp_pkg::OP_READ16))
    |=> ($stable(out_vram_word_address) && $stable(out_cgram_address) &&
         $stable(out_cgram_low_pending) && $stable(out_brightness) &&
         !out_access_error))
    else $error("read altered state or flagged error");

  // CGADD write drops any half-assembled palette word
  a_cgadd_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == vrp_pkg::OP_WRITE8 &&
     in_register_select == vrp_pkg::SEL_CGADD)
    |=> !out_cgram_low_pending)
    else $error("palette latch not cleared by CGADD");

endmodule

>>> src/vrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_ctrl
// Sequencer: accept, optional high-byte step, hold result until taken.
// ----------------------------------------------------------------------------
module vrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  vrp_pkg::dp_stat_t stat,
  output vrp_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HIGH = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_second ? ST_HIGH : ST_OUT;
        end
      end
      ST_HIGH: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign cmd.step_first  = in_valid && (state_r == ST_IDLE);
  assign cmd.step_second = (state_r == ST_HIGH);

endmodule

>>> src/vrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_dp
// Register file, byte-write decode, VRAM and CGRAM write paths.
// ----------------------------------------------------------------------------
module vrp_dp #(
  parameter int VRAM_BYTES    = vrp_pkg::VRAM_BYTES_DEF,
  parameter int CGRAM_ENTRIES = vrp_pkg::CGRAM_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vrp_pkg::ctl_cmd_t              cmd,
  output vrp_pkg::dp_stat_t              stat,
  input  logic [vrp_pkg::OP_W-1:0]       in_operation,
  input  logic [vrp_pkg::SEL_W-1:0]      in_register_select,
  input  logic [vrp_pkg::DATA_W-1:0]     in_write_data,
  output logic                           access_error,
  output logic                           forced_blank,
  output logic [vrp_pkg::BRIGHT_W-1:0]   brightness,
  output logic                           nmi_enable,
  output logic [vrp_pkg::VADDR_W-1:0]    vram_word_address,
  output logic [vrp_pkg::CADDR_W-1:0]    cgram_address,
  output logic                           cgram_low_pending
);

  localparam int VA_W = (VRAM_BYTES > 1) ? $clog2(VRAM_BYTES) : 1;
  localparam int CA_W = (CGRAM_ENTRIES > 1) ? $clog2(CGRAM_ENTRIES) : 1;
  localparam int XW   = vrp_pkg::VADDR_W;          // byte address width
  localparam int RW   = 2 * XW + 1;                // reciprocal width
  localparam int PW   = XW + RW;                   // product width
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << (2 * XW)) + 64'(VRAM_BYTES) - 64'd1) / 64'(VRAM_BYTES));
  localparam logic [XW:0] NV = (XW + 1)'(VRAM_BYTES);

  // architectural state
  logic                              blank_r, blank_nxt;
  logic [vrp_pkg::BRIGHT_W-1:0]      bright_r, bright_nxt;
  logic                              nmi_r, nmi_nxt;
  logic [vrp_pkg::VADDR_W-1:0]       vaddr_r, vaddr_nxt;
  logic                              inc_hi_r, inc_hi_nxt;
  logic [vrp_pkg::STEP_SEL_W-1:0]    step_sel_r, step_sel_nxt;
  logic [vrp_pkg::CADDR_W-1:0]       paddr_r, paddr_nxt;
  logic [vrp_pkg::BYTE_W-1:0]        plat_r, plat_nxt;
  logic                              pvalid_r, pvalid_nxt;

  // captured high half of a split write
  logic [vrp_pkg::BYTE_W-1:0]        hi_byte_r;
  logic [vrp_pkg::SEL_W-1:0]         hi_sel_r;
  logic                              err_r;

  // byte-write decode
  logic [vrp_pkg::SEL_W-1:0]         bsel;
  logic [vrp_pkg::BYTE_W-1:0]        bval;
  logic                              apply;
  logic                              err_nxt;
  logic [vrp_pkg::VADDR_W-1:0]       vstep;
  logic                              vw_en;
  logic [XW-1:0]                     vw_x;
  logic                              cw_en;

  // VRAM write pipeline: byte address reduced modulo VRAM_BYTES
  logic                              vw_en_r, vw2_en_r;
  logic [XW-1:0]                     vw_x_r, vw2_x_r;
  logic [vrp_pkg::BYTE_W-1:0]        vw_d_r, vw2_d_r;
  logic [PW-1:0]                     vw_prod_r;
  logic [XW-1:0]                     quo;
  logic [2*XW:0]                     qn;
  logic [XW:0]                       rem;

  logic [vrp_pkg::BYTE_W-1:0]        vram_mem [VRAM_BYTES];
  logic [vrp_pkg::PAL_W-1:0]         cgram_mem [CGRAM_ENTRIES];

  assign stat.need_second = (in_operation == vrp_pkg::OP_WRITE16) &&
                            ((in_register_select == vrp_pkg::SEL_VMADDL) ||
                             (in_register_select == vrp_pkg::SEL_VMDATAL));

  assign bsel  = cmd.step_second ? hi_sel_r : in_register_select;
  assign bval  = cmd.step_second ? hi_byte_r : in_write_data[vrp_pkg::BYTE_W-1:0];
  assign apply = cmd.step_second ||
                 (cmd.step_first && ((in_operation == vrp_pkg::OP_WRITE8) ||
                                     stat.need_second));

  always_comb begin
    case (step_sel_r)
      vrp_pkg::STEP_SEL_1:  vstep = vrp_pkg::STEP_1;
      vrp_pkg::STEP_SEL_32: vstep = vrp_pkg::STEP_32;
      default:              vstep = vrp_pkg::STEP_128;
    endcase
  end

  // error flag for the item being accepted
  always_comb begin
    err_nxt = 1'b0;
    case (in_operation)
      vrp_pkg::OP_WRITE8: begin
        if (in_register_select == vrp_pkg::SEL_VMAIN) begin
          err_nxt = (in_write_data[3:2] != 2'b00);
        end else begin
          err_nxt = (in_register_select > vrp_pkg::SEL_OTHER);
        end
      end
      vrp_pkg::OP_WRITE16: begin
        err_nxt = !((in_register_select == vrp_pkg::SEL_VTIMEL) ||
                    (in_register_select == vrp_pkg::SEL_OAMADDL) ||
                    (in_register_select == vrp_pkg::SEL_VMADDL) ||
                    (in_register_select == vrp_pkg::SEL_VMDATAL));
      end
      default: begin
        err_nxt = 1'b0;
      end
    endcase
  end

  // one byte write to one register
  always_comb begin
    blank_nxt    = blank_r;
    bright_nxt   = bright_r;
    nmi_nxt      = nmi_r;
    vaddr_nxt    = vaddr_r;
    inc_hi_nxt   = inc_hi_r;
    step_sel_nxt = step_sel_r;
    paddr_nxt    = paddr_r;
    plat_nxt     = plat_r;
    pvalid_nxt   = pvalid_r;
    vw_en        = 1'b0;
    vw_x         = {vaddr_r[XW-2:0], 1'b0};
    cw_en        = 1'b0;
    if (apply) begin
      case (bsel)
        vrp_pkg::SEL_INIDISP: begin
          blank_nxt  = bval[7];
          bright_nxt = bval[vrp_pkg::BRIGHT_W-1:0];
        end
        vrp_pkg::SEL_NMITIMEN: begin
          // H/V IRQ enables are not supported: such writes are dropped
          if (bval[5:4] == 2'b00) begin
            nmi_nxt = bval[7];
          end
        end
        vrp_pkg::SEL_VMAIN: begin
          if (bval[3:2] == 2'b00) begin
            inc_hi_nxt   = bval[7];
            step_sel_nxt = bval[vrp_pkg::STEP_SEL_W-1:0];
          end
        end
        vrp_pkg::SEL_VMADDL: begin
          vaddr_nxt = {vaddr_r[15:8], bval};
        end
        vrp_pkg::SEL_VMADDH: begin
          vaddr_nxt = {bval, vaddr_r[7:0]};
        end
        vrp_pkg::SEL_VMDATAL: begin
          vw_en = 1'b1;
          vw_x  = {vaddr_r[XW-2:0], 1'b0};
          if (!inc_hi_r) begin
            vaddr_nxt = vaddr_r + vstep;
          end
        end
        vrp_pkg::SEL_VMDATAH: begin
          vw_en = 1'b1;
          vw_x  = {vaddr_r[XW-2:0], 1'b1};
          if (inc_hi_r) begin
            vaddr_nxt = vaddr_r + vstep;
          end
        end
        vrp_pkg::SEL_CGADD: begin
          paddr_nxt  = bval;
          plat_nxt   = '0;
          pvalid_nxt = 1'b0;
        end
        vrp_pkg::SEL_CGDATA: begin
          if (pvalid_r) begin
            cw_en      = 1'b1;
            paddr_nxt  = paddr_r + 8'd1;
            pvalid_nxt = 1'b0;
          end else begin
            plat_nxt   = bval;
            pvalid_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r    <= 1'b0;
      bright_r   <= '0;
      nmi_r      <= 1'b0;
      vaddr_r    <= '0;
      inc_hi_r   <= 1'b0;
      step_sel_r <= '0;
      paddr_r    <= '0;
      plat_r     <= '0;
      pvalid_r   <= 1'b0;
      vw_en_r    <= 1'b0;
      vw2_en_r   <= 1'b0;
    end else begin
      blank_r    <= blank_nxt;
      bright_r   <= bright_nxt;
      nmi_r      <= nmi_nxt;
      vaddr_r    <= vaddr_nxt;
      inc_hi_r   <= inc_hi_nxt;
      step_sel_r <= step_sel_nxt;
      paddr_r    <= paddr_nxt;
      plat_r     <= plat_nxt;
      pvalid_r   <= pvalid_nxt;
      vw_en_r    <= vw_en;
      vw2_en_r   <= vw_en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_first) begin
      err_r     <= err_nxt;
      hi_byte_r <= in_write_data[vrp_pkg::DATA_W-1:vrp_pkg::BYTE_W];
      hi_sel_r  <= in_register_select + 4'd1;
    end
    vw_x_r    <= vw_x;
    vw_d_r    <= bval;
    vw_prod_r <= PW'(vw_x_r) * PW'(RECIP);
    vw2_x_r   <= vw_x_r;
    vw2_d_r   <= vw_d_r;
  end

  // quotient by reciprocal, then remainder; exact for 16-bit byte addresses
  assign quo = vw_prod_r[PW-2:2*XW];
  assign qn  = (2*XW+1)'(quo) * (2*XW+1)'(NV);
  assign rem = {1'b0, vw2_x_r} - qn[XW:0];

  always_ff @(posedge clk) begin
    if (vw2_en_r) begin
      vram_mem[rem[VA_W-1:0]] <= vw2_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cgram_mem[paddr_r[CA_W-1:0]] <= {bval[6:0], plat_r};
    end
  end

  assign access_error      = err_r;
  assign forced_blank      = blank_r;
  assign brightness        = bright_r;
  assign nmi_enable        = nmi_r;
  assign vram_word_address = vaddr_r;
  assign cgram_address     = paddr_r;
  assign cgram_low_pending = pvalid_r;

endmodule
